### hw/rtl/stem_pkg.sv
// Package for the sync time error monitor: constants, record types and codes.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package stem_pkg;

    // Lock detection window and the run length that marks the lock point.
    localparam int LOCK_WINDOW   = 10;
    localparam int LOCK_RUN      = 5;
    localparam int WIN_CNT_W     = $clog2(LOCK_WINDOW + 1);
    localparam int RUN_CNT_W     = $clog2(LOCK_RUN + 1);
    // Locked needs at least 80 percent good events in the window.
    localparam int LOCK_MIN_GOOD = (LOCK_WINDOW * 4 + 4) / 5;

    // Sanity limits on the measurement.
    localparam logic [63:0] MAX_ERR_NS   = 64'd10000000;
    localparam logic [63:0] MAX_DELAY_NS = 64'd1000000;

    // Signed extremes used as the empty values of min and max.
    localparam logic [63:0] ERR_MAX_POS = {1'b0, {63{1'b1}}};
    localparam logic [63:0] ERR_MIN_NEG = {1'b1, {63{1'b0}}};

    // Configuration registers.
    localparam int          TARGET_W     = 24;
    localparam int          CFG_IDX_W    = 1;
    localparam int          CFG_DATA_W   = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd1;
    localparam logic [TARGET_W-1:0]  TARGET_RESET = 24'd80;

    // Nanoseconds to seconds: 10^9 = 2^9 * 5^9. The low nine bits are shifted
    // out first, the odd factor is divided by a reciprocal multiply.
    localparam int           SEC_SHIFT   = 9;
    localparam int           SEC_Y_W     = 64 - SEC_SHIFT;
    localparam int           DIV_Y_W     = 53;
    localparam int           RECIP_W     = 54;
    localparam int           RECIP_SHIFT = 74;
    localparam logic [20:0]  SEC_ODD     = 21'd1953125;
    // Shifted deltas at or above 2^32 * 5^9 saturate the result.
    localparam logic [DIV_Y_W-1:0] SEC_SAT_Y = 53'd8388608000000000;
    localparam logic [RECIP_SHIFT:0] RECIP_NUM = 75'd1 << RECIP_SHIFT;
    localparam logic [RECIP_W-1:0]   SEC_RECIP = RECIP_W'(RECIP_NUM / 75'd1953125);

    // Stream widths.
    localparam int IN_TDATA_W  = 336;
    localparam int OUT_TDATA_W = 392;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic                enable;
        logic [TARGET_W-1:0] target;
    } t_cfg;

    // One accepted input beat.
    typedef struct packed {
        logic        cmd;
        logic [63:0] master_tx;
        logic [63:0] slave_rx;
        logic [63:0] link_delay;
        logic [63:0] correction;
        logic [15:0] seq;
        logic [63:0] arrival;
    } t_in_rec;

    // Measured error handed to the statistics stage.
    typedef struct packed {
        logic        cmd;
        logic [15:0] seq;
        logic [63:0] arrival;
        logic [63:0] err;
        logic        err_ok;
        logic        good;
    } t_err_rec;

    // Statistics after one event, before lock figures are finished.
    typedef struct packed {
        logic                   accepted;
        logic [63:0]            err;
        logic                   err_ok;
        logic [63:0]            min_err;
        logic [63:0]            max_err;
        logic [63:0]            sum_err;
        logic [31:0]            cnt_valid;
        logic [31:0]            cnt_outlier;
        logic [31:0]            run_best;
        logic [LOCK_WINDOW-1:0] win_bits;
        logic                   win_full;
        logic                   lock_seen;
        logic [63:0]            lock_delta;
    } t_stat_rec;

    // Finished result beat.
    typedef struct packed {
        logic        accepted;
        logic [63:0] time_error;
        logic        error_valid;
        logic [63:0] min_err;
        logic [63:0] max_err;
        logic [63:0] sum_err;
        logic [31:0] valid_count;
        logic [31:0] outlier_cnt;
        logic [31:0] best_good_run;
        logic        locked;
        logic        lock_seen;
        logic [31:0] lock_time_s;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/stem_err_calc.sv
// Input register and time error pipeline: subtraction, magnitude and checks.
// Depends on stem_pkg.
`default_nettype none

module stem_err_calc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_vld,
    output logic               o_in_rdy,
    input  stem_pkg::t_in_rec  i_in,
    input  stem_pkg::t_cfg     i_cfg,
    output logic               o_out_vld,
    input  logic               i_out_rdy,
    output stem_pkg::t_err_rec o_out
);
    import stem_pkg::*;

    typedef struct packed {
        logic        cmd;
        logic [15:0] seq;
        logic [63:0] arrival;
        logic [63:0] diff_ts;
        logic [63:0] sum_dly;
        logic        ts_nz;
        logic        dly_ok;
    } t_s1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] seq;
        logic [63:0] arrival;
        logic [63:0] err;
        logic        ts_nz;
        logic        dly_ok;
    } t_s2;

    logic     r_v0, r_v1, r_v2, r_v3;
    logic     rdy0, rdy1, rdy2, rdy3;
    t_in_rec  r_s0;
    t_s1      r_s1, n_s1;
    t_s2      r_s2, n_s2;
    t_err_rec r_s3, n_s3;
    logic [63:0] mag;

    // A stage takes a new beat when it is empty or its beat moves on.
    assign rdy3 = !r_v3 || i_out_rdy;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign rdy0 = !r_v0 || rdy1;
    assign o_in_rdy  = rdy0;
    assign o_out_vld = r_v3;
    assign o_out     = r_s3;

    // Stage 1: timestamp difference, delay plus correction, input checks.
    always_comb begin
        n_s1.cmd     = r_s0.cmd;
        n_s1.seq     = r_s0.seq;
        n_s1.arrival = r_s0.arrival;
        n_s1.diff_ts = r_s0.slave_rx - r_s0.master_tx;
        n_s1.sum_dly = r_s0.link_delay + r_s0.correction;
        n_s1.ts_nz   = (r_s0.master_tx != 64'd0) && (r_s0.slave_rx != 64'd0);
        n_s1.dly_ok  = r_s0.link_delay <= MAX_DELAY_NS;
    end

    // Stage 2: the time error itself, modulo 2^64.
    always_comb begin
        n_s2.cmd     = r_s1.cmd;
        n_s2.seq     = r_s1.seq;
        n_s2.arrival = r_s1.arrival;
        n_s2.err     = r_s1.diff_ts - r_s1.sum_dly;
        n_s2.ts_nz   = r_s1.ts_nz;
        n_s2.dly_ok  = r_s1.dly_ok;
    end

    // Stage 3: magnitude against the sanity limit and the target.
    always_comb begin
        mag          = r_s2.err[63] ? (64'd0 - r_s2.err) : r_s2.err;
        n_s3.cmd     = r_s2.cmd;
        n_s3.seq     = r_s2.seq;
        n_s3.arrival = r_s2.arrival;
        n_s3.err     = r_s2.err;
        n_s3.err_ok  = r_s2.ts_nz && r_s2.dly_ok && (mag <= MAX_ERR_NS);
        n_s3.good    = n_s3.err_ok && (mag <= {{(64-TARGET_W){1'b0}}, i_cfg.target});
    end

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy0) r_v0 <= i_in_vld;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in_vld) r_s0 <= i_in;
        if (rdy1 && r_v0)     r_s1 <= n_s1;
        if (rdy2 && r_v1)     r_s2 <= n_s2;
        if (rdy3 && r_v2)     r_s3 <= n_s3;
    end

endmodule

`default_nettype wire

### hw/rtl/stem_stats.sv
// Running statistics, duplicate filter, lock window and lock point capture.
// Depends on stem_pkg.
`default_nettype none

module stem_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_enable,
    input  logic                i_in_vld,
    output logic                o_in_rdy,
    input  stem_pkg::t_err_rec  i_in,
    output logic                o_out_vld,
    input  logic                i_out_rdy,
    output stem_pkg::t_stat_rec o_out
);
    import stem_pkg::*;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    logic                   r_vld;
    logic                   load;
    logic                   acc;
    t_stat_rec              r_rec, n_rec;

    logic [15:0]            r_last_seq,   n_last_seq;
    logic [LOCK_WINDOW-1:0] r_win_bits,   n_win_bits;
    logic [WIN_CNT_W-1:0]   r_win_fill,   n_win_fill;
    logic [63:0]            r_min,        n_min;
    logic [63:0]            r_max,        n_max;
    logic [63:0]            r_sum,        n_sum;
    logic [31:0]            r_cnt_valid,  n_cnt_valid;
    logic [31:0]            r_cnt_out,    n_cnt_out;
    logic [31:0]            r_run_now,    n_run_now;
    logic [31:0]            r_run_best,   n_run_best;
    logic [RUN_CNT_W-1:0]   r_lock_run,   n_lock_run;
    logic [63:0]            r_first_time, n_first_time;
    logic                   r_have_first, n_have_first;
    logic                   r_lock_seen,  n_lock_seen;
    logic [63:0]            r_lock_delta, n_lock_delta;

    assign o_in_rdy  = !r_vld || i_out_rdy;
    assign load      = o_in_rdy && i_in_vld;
    assign o_out_vld = r_vld;
    assign o_out     = r_rec;

    // Next state for one event: clear, ignore, or record.
    always_comb begin
        acc          = 1'b0;
        n_last_seq   = r_last_seq;
        n_win_bits   = r_win_bits;
        n_win_fill   = r_win_fill;
        n_min        = r_min;
        n_max        = r_max;
        n_sum        = r_sum;
        n_cnt_valid  = r_cnt_valid;
        n_cnt_out    = r_cnt_out;
        n_run_now    = r_run_now;
        n_run_best   = r_run_best;
        n_lock_run   = r_lock_run;
        n_first_time = r_first_time;
        n_have_first = r_have_first;
        n_lock_seen  = r_lock_seen;
        n_lock_delta = r_lock_delta;

        if (i_in.cmd) begin
            // Clear keeps the last sequence number.
            n_win_bits   = '0;
            n_win_fill   = '0;
            n_min        = ERR_MAX_POS;
            n_max        = ERR_MIN_NEG;
            n_sum        = '0;
            n_cnt_valid  = '0;
            n_cnt_out    = '0;
            n_run_now    = '0;
            n_run_best   = '0;
            n_lock_run   = '0;
            n_first_time = '0;
            n_have_first = 1'b0;
            n_lock_seen  = 1'b0;
            n_lock_delta = '0;
        end else if (i_enable && (i_in.seq != r_last_seq)) begin
            acc        = 1'b1;
            n_last_seq = i_in.seq;
            if (!r_have_first) begin
                n_have_first = 1'b1;
                n_first_time = i_in.arrival;
            end

            // Figures over valid errors only.
            if (i_in.err_ok) begin
                if ($signed(i_in.err) < $signed(r_min)) n_min = i_in.err;
                if ($signed(i_in.err) > $signed(r_max)) n_max = i_in.err;
                n_sum       = r_sum + i_in.err;
                n_cnt_valid = sat_inc(r_cnt_valid);
                if (i_in.good) begin
                    n_run_now = sat_inc(r_run_now);
                    if (n_run_now > r_run_best) n_run_best = n_run_now;
                end else begin
                    n_cnt_out = sat_inc(r_cnt_out);
                    n_run_now = '0;
                end
            end

            // Lock window shifts on every accepted event.
            n_win_bits = {r_win_bits[LOCK_WINDOW-2:0], i_in.good};
            if (r_win_fill < WIN_CNT_W'(LOCK_WINDOW)) n_win_fill = r_win_fill + 1'b1;

            // First run of good events fixes the lock point.
            if (i_in.good) begin
                if (r_lock_run < RUN_CNT_W'(LOCK_RUN)) n_lock_run = r_lock_run + 1'b1;
                if ((n_lock_run >= RUN_CNT_W'(LOCK_RUN)) && !r_lock_seen) begin
                    n_lock_seen  = 1'b1;
                    n_lock_delta = i_in.arrival - n_first_time;
                end
            end else begin
                n_lock_run = '0;
            end
        end
    end

    // Result record shows the state after the event.
    always_comb begin
        n_rec.accepted    = acc;
        n_rec.err         = acc ? i_in.err : 64'd0;
        n_rec.err_ok      = acc && i_in.err_ok;
        n_rec.min_err     = n_min;
        n_rec.max_err     = n_max;
        n_rec.sum_err     = n_sum;
        n_rec.cnt_valid   = n_cnt_valid;
        n_rec.cnt_outlier = n_cnt_out;
        n_rec.run_best    = n_run_best;
        n_rec.win_bits    = n_win_bits;
        n_rec.win_full    = n_win_fill == WIN_CNT_W'(LOCK_WINDOW);
        n_rec.lock_seen   = n_lock_seen;
        n_rec.lock_delta  = n_lock_delta;
    end

    // Statistics state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= 1'b0;
            r_last_seq   <= '0;
            r_win_bits   <= '0;
            r_win_fill   <= '0;
            r_min        <= ERR_MAX_POS;
            r_max        <= ERR_MIN_NEG;
            r_sum        <= '0;
            r_cnt_valid  <= '0;
            r_cnt_out    <= '0;
            r_run_now    <= '0;
            r_run_best   <= '0;
            r_lock_run   <= '0;
            r_first_time <= '0;
            r_have_first <= 1'b0;
            r_lock_seen  <= 1'b0;
            r_lock_delta <= '0;
        end else begin
            if (o_in_rdy) r_vld <= i_in_vld;
            if (load) begin
                r_last_seq   <= n_last_seq;
                r_win_bits   <= n_win_bits;
                r_win_fill   <= n_win_fill;
                r_min        <= n_min;
                r_max        <= n_max;
                r_sum        <= n_sum;
                r_cnt_valid  <= n_cnt_valid;
                r_cnt_out    <= n_cnt_out;
                r_run_now    <= n_run_now;
                r_run_best   <= n_run_best;
                r_lock_run   <= n_lock_run;
                r_first_time <= n_first_time;
                r_have_first <= n_have_first;
                r_lock_seen  <= n_lock_seen;
                r_lock_delta <= n_lock_delta;
            end
        end
    end

    // Result record register.
    always_ff @(posedge i_clk) begin
        if (load) r_rec <= n_rec;
    end

endmodule

`default_nettype wire

### hw/rtl/stem_sec_div.sv
// Lock figures: window vote and lock delay in whole seconds, by a pipelined
// reciprocal multiply for the divide by 10^9. Depends on stem_pkg.
`default_nettype none

module stem_sec_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_vld,
    output logic                o_in_rdy,
    input  stem_pkg::t_stat_rec i_in,
    output logic                o_out_vld,
    input  logic                i_out_rdy,
    output stem_pkg::t_result   o_out
);
    import stem_pkg::*;

    typedef struct packed {
        t_result              res;
        logic                 sat;
        logic [DIV_Y_W-1:0]   y;
        logic [RECIP_W-1:0]   pp_hh;
        logic [RECIP_W-1:0]   pp_hl;
        logic [RECIP_W-1:0]   pp_lh;
        logic [RECIP_W-1:0]   pp_ll;
    } t_d1;

    typedef struct packed {
        t_result              res;
        logic                 sat;
        logic [DIV_Y_W-1:0]   y;
        logic [RECIP_W-1:0]   pp_hh;
        logic [RECIP_W:0]     mid;
        logic [RECIP_W-1:0]   pp_ll;
    } t_d2;

    typedef struct packed {
        t_result              res;
        logic                 sat;
        logic [DIV_Y_W-1:0]   y;
        logic [31:0]          q_est;
    } t_d3;

    typedef struct packed {
        t_result              res;
        logic                 sat;
        logic [DIV_Y_W-1:0]   y;
        logic [31:0]          q_est;
        logic [DIV_Y_W-1:0]   prod;
    } t_d4;

    function automatic logic [WIN_CNT_W-1:0] pop_count(input logic [LOCK_WINDOW-1:0] v);
        logic [WIN_CNT_W-1:0] c;
        c = '0;
        for (int k = 0; k < LOCK_WINDOW; k++) c = c + WIN_CNT_W'(v[k]);
        return c;
    endfunction

    logic    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic    rdy1, rdy2, rdy3, rdy4, rdy5;
    t_d1     r_d1, n_d1;
    t_d2     r_d2, n_d2;
    t_d3     r_d3, n_d3;
    t_d4     r_d4, n_d4;
    t_result r_d5, n_d5;

    logic [SEC_Y_W-1:0]       y_full;
    logic [DIV_Y_W-1:0]       y_div;
    logic [106:0]             tot;
    logic [DIV_Y_W-1:0]       rem;

    assign rdy5 = !r_v5 || i_out_rdy;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_in_rdy  = rdy1;
    assign o_out_vld = r_v5;
    assign o_out     = r_d5;

    // Stage 1: window vote, saturation test and four partial products.
    always_comb begin
        y_full = i_in.lock_delta[63:SEC_SHIFT];
        y_div  = y_full[DIV_Y_W-1:0];

        n_d1.res.accepted      = i_in.accepted;
        n_d1.res.time_error    = i_in.err;
        n_d1.res.error_valid   = i_in.err_ok;
        n_d1.res.min_err       = i_in.min_err;
        n_d1.res.max_err       = i_in.max_err;
        n_d1.res.sum_err       = i_in.sum_err;
        n_d1.res.valid_count   = i_in.cnt_valid;
        n_d1.res.outlier_cnt   = i_in.cnt_outlier;
        n_d1.res.best_good_run = i_in.run_best;
        n_d1.res.locked        = i_in.win_full &&
                                 (pop_count(i_in.win_bits) >= WIN_CNT_W'(LOCK_MIN_GOOD));
        n_d1.res.lock_seen     = i_in.lock_seen;
        n_d1.res.lock_time_s   = '0;

        n_d1.sat   = y_full >= SEC_Y_W'(SEC_SAT_Y);
        n_d1.y     = y_div;
        n_d1.pp_hh = RECIP_W'(y_div[52:27]) * RECIP_W'(SEC_RECIP[53:27]);
        n_d1.pp_hl = RECIP_W'(y_div[52:27]) * RECIP_W'(SEC_RECIP[26:0]);
        n_d1.pp_lh = RECIP_W'(y_div[26:0])  * RECIP_W'(SEC_RECIP[53:27]);
        n_d1.pp_ll = RECIP_W'(y_div[26:0])  * RECIP_W'(SEC_RECIP[26:0]);
    end

    // Stage 2: sum of the cross products.
    always_comb begin
        n_d2.res   = r_d1.res;
        n_d2.sat   = r_d1.sat;
        n_d2.y     = r_d1.y;
        n_d2.pp_hh = r_d1.pp_hh;
        n_d2.mid   = {1'b0, r_d1.pp_hl} + {1'b0, r_d1.pp_lh};
        n_d2.pp_ll = r_d1.pp_ll;
    end

    // Stage 3: full product, quotient estimate is low by at most one.
    always_comb begin
        tot = {r_d2.pp_hh[52:0], 54'd0} + {25'd0, r_d2.mid, 27'd0} + {53'd0, r_d2.pp_ll};
        n_d3.res   = r_d2.res;
        n_d3.sat   = r_d2.sat;
        n_d3.y     = r_d2.y;
        n_d3.q_est = tot[RECIP_SHIFT+31:RECIP_SHIFT];
    end

    // Stage 4: estimate times the divisor.
    always_comb begin
        n_d4.res   = r_d3.res;
        n_d4.sat   = r_d3.sat;
        n_d4.y     = r_d3.y;
        n_d4.q_est = r_d3.q_est;
        n_d4.prod  = DIV_Y_W'(r_d3.q_est) * DIV_Y_W'(SEC_ODD);
    end

    // Stage 5: remainder correction and saturation.
    always_comb begin
        rem  = r_d4.y - r_d4.prod;
        n_d5 = r_d4.res;
        if (r_d4.sat) begin
            n_d5.lock_time_s = '1;
        end else if (rem >= DIV_Y_W'(SEC_ODD)) begin
            n_d5.lock_time_s = r_d4.q_est + 32'd1;
        end else begin
            n_d5.lock_time_s = r_d4.q_est;
        end
    end

    // Stage occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_vld;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_vld) r_d1 <= n_d1;
        if (rdy2 && r_v1)     r_d2 <= n_d2;
        if (rdy3 && r_v2)     r_d3 <= n_d3;
        if (rdy4 && r_v3)     r_d4 <= n_d4;
        if (rdy5 && r_v4)     r_d5 <= n_d5;
    end

endmodule

`default_nettype wire

### hw/rtl/sync_time_error_monitor.sv
// Top level of the sync time error monitor: stream ports, configuration
// registers and the error, statistics and lock-second pipeline stages.
// Depends on stem_pkg, stem_err_calc, stem_stats and stem_sec_div.
//
//   Channel   Direction  Beat contents
//   s_axis    in         one sync event or a clear command
//   m_axis    out        error and statistics after that beat
//   i_cfg_*   in         register write, index 0 enable, index 1 target
//
// Every input beat gives exactly one output beat; with m_axis ready, one beat per
// cycle is sustained.
// The path holds ten registers: the input register, three error stages, the
// statistics register and five stages of the seconds divider.
// Reset clears statistics and sequence filter, and sets the register defaults.
// A stall on m_axis fills empty stages first; s_axis stalls only once every
// stage holds a beat.
`default_nettype none

module sync_time_error_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [stem_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [stem_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // From bit 0: master_tx_ns[64], slave_rx_ns[64], link_delay_ns[64],
    // correction_ns[64], seq_number[16], arrival_time_ns[64].
    input  logic [stem_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command: 0 record sync event, 1 clear statistics.
    input  logic                              s_axis_tuser,
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // From bit 0: accepted[1], time_error_ns[64], error_valid[1],
    // min_error_ns[64], max_error_ns[64], error_sum_ns[64], valid_count[32],
    // outlier_cnt[32], best_good_run[32], locked[1], lock_seen[1],
    // lock_time_s[32], zero fill[4].
    output logic [stem_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import stem_pkg::*;

    t_cfg      r_cfg;
    t_in_rec   in_rec;
    t_err_rec  err_rec;
    t_stat_rec stat_rec;
    t_result   res;
    logic      err_vld, err_rdy;
    logic      stat_vld, stat_rdy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b0;
            r_cfg.target <= TARGET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_cfg.enable <= i_cfg_wdata[0];
                CFG_TARGET: r_cfg.target <= i_cfg_wdata[TARGET_W-1:0];
                default: ;
            endcase
        end
    end

    // Input beat unpacking.
    always_comb begin
        in_rec.cmd        = s_axis_tuser;
        in_rec.master_tx  = s_axis_tdata[63:0];
        in_rec.slave_rx   = s_axis_tdata[127:64];
        in_rec.link_delay = s_axis_tdata[191:128];
        in_rec.correction = s_axis_tdata[255:192];
        in_rec.seq        = s_axis_tdata[271:256];
        in_rec.arrival    = s_axis_tdata[335:272];
    end

    stem_err_calc u_err_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .o_in_rdy  (s_axis_tready),
        .i_in      (in_rec),
        .i_cfg     (r_cfg),
        .o_out_vld (err_vld),
        .i_out_rdy (err_rdy),
        .o_out     (err_rec)
    );

    stem_stats u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_enable  (r_cfg.enable),
        .i_in_vld  (err_vld),
        .o_in_rdy  (err_rdy),
        .i_in      (err_rec),
        .o_out_vld (stat_vld),
        .i_out_rdy (stat_rdy),
        .o_out     (stat_rec)
    );

    stem_sec_div u_sec_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (stat_vld),
        .o_in_rdy  (stat_rdy),
        .i_in      (stat_rec),
        .o_out_vld (m_axis_tvalid),
        .i_out_rdy (m_axis_tready),
        .o_out     (res)
    );

    // Output beat packing.
    assign m_axis_tdata = {4'd0,
                           res.lock_time_s,
                           res.lock_seen,
                           res.locked,
                           res.best_good_run,
                           res.outlier_cnt,
                           res.valid_count,
                           res.sum_err,
                           res.max_err,
                           res.min_err,
                           res.error_valid,
                           res.time_error,
                           res.accepted};

endmodule

`default_nettype wire

### sim/sync_time_error_monitor_tb.sv
// Self-checking testbench for sync_time_error_monitor: streams sync events and
// clears, predicts every result beat in a local model and compares each field.
// Depends on stem_pkg and the sync_time_error_monitor RTL.
`default_nettype none

module sync_time_error_monitor_tb;

    import stem_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 16;

    // Clock, reset and the block's ports.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = CFG_ENABLE;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // From bit 0: master_tx_ns, slave_rx_ns, link_delay_ns, correction_ns,
    // seq_number, arrival_time_ns.
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // command.
    logic                    s_axis_tuser = 1'b0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // From bit 0: accepted, time_error_ns, error_valid, min_error_ns,
    // max_error_ns, error_sum_ns, valid_count, outlier_cnt, best_good_run,
    // locked, lock_seen, lock_time_s, zero fill.
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;

    // Configuration copy held by the predictor.
    bit                      cfg_en;
    logic [TARGET_W-1:0]     cfg_target;

    // Predictor state.
    logic [15:0]             last_seq;
    logic [LOCK_WINDOW-1:0]  win_bits;
    int                      win_fill;
    logic signed [63:0]      min_seen;
    logic signed [63:0]      max_seen;
    logic [63:0]             sum_seen;
    logic [31:0]             cnt_valid;
    logic [31:0]             cnt_outliers;
    logic [31:0]             run_now;
    logic [31:0]             run_best;
    int                      lock_run;
    logic [63:0]             first_time;
    bit                      have_first;
    bit                      lock_found;
    logic [31:0]             lock_secs;

    // Expected result beats, oldest first.
    t_result                 pending_stats[$];

    logic [63:0]             arrival_ns = 64'd1000;
    bit                      src_idle_on = 1'b1;
    bit                      sink_idle_on = 1'b1;
    int                      sink_wait = 0;
    int                      result_index = 0;
    int                      mismatch_count = 0;
    int                      idle_cycles = 0;

    sync_time_error_monitor DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 10 unit period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Statistics, lock window and lock search back to their empty values.
    function automatic void clear_statistics();
        win_bits = '0;
        win_fill = 0;
        min_seen = ERR_MAX_POS;
        max_seen = ERR_MIN_NEG;
        sum_seen = '0;
        cnt_valid = '0;
        cnt_outliers = '0;
        run_now = '0;
        run_best = '0;
        lock_run = 0;
        first_time = '0;
        have_first = 1'b0;
        lock_found = 1'b0;
        lock_secs = '0;
    endfunction

    // Applies one beat to the predictor state and returns the result beat.
    function automatic t_result compute_monitor_result(t_in_rec ev);
        t_result     r;
        logic [63:0] err;
        logic [63:0] mag;
        logic [63:0] delta;
        bit          acc;
        bit          valid;
        bit          good;
        r = '0;
        err = '0;
        acc = 1'b0;
        valid = 1'b0;
        if (ev.cmd) begin
            clear_statistics();
        end else if (cfg_en && ev.seq != last_seq) begin
            acc = 1'b1;
            last_seq = ev.seq;
            err = ev.slave_rx - ev.master_tx - ev.link_delay - ev.correction;
            mag = err[63] ? (64'd0 - err) : err;
            valid = ev.master_tx != 0 && ev.slave_rx != 0 && mag <= MAX_ERR_NS
                    && ev.link_delay <= MAX_DELAY_NS;
            good = valid && mag <= {40'd0, cfg_target};
            if (!have_first) begin
                have_first = 1'b1;
                first_time = ev.arrival;
            end
            if (valid) begin
                if ($signed(err) < min_seen) min_seen = err;
                if ($signed(err) > max_seen) max_seen = err;
                sum_seen = sum_seen + err;
                cnt_valid = sat_inc(cnt_valid);
                if (good) begin
                    run_now = sat_inc(run_now);
                    if (run_now > run_best) run_best = run_now;
                end else begin
                    cnt_outliers = sat_inc(cnt_outliers);
                    run_now = '0;
                end
            end
            win_bits = {win_bits[LOCK_WINDOW-2:0], good};
            if (win_fill < LOCK_WINDOW) win_fill++;
            if (good) begin
                if (lock_run < LOCK_RUN) lock_run++;
                if (lock_run >= LOCK_RUN && !lock_found) begin
                    delta = (ev.arrival - first_time) / 64'd1000000000;
                    lock_found = 1'b1;
                    lock_secs = (delta > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                   : delta[31:0];
                end
            end else begin
                lock_run = 0;
            end
        end
        r.accepted = acc;
        r.time_error = err;
        r.error_valid = valid;
        r.min_err = min_seen;
        r.max_err = max_seen;
        r.sum_err = sum_seen;
        r.valid_count = cnt_valid;
        r.outlier_cnt = cnt_outliers;
        r.best_good_run = run_best;
        r.locked = (win_fill >= LOCK_WINDOW)
                   && ($countones(win_bits) * 5 >= LOCK_WINDOW * 4);
        r.lock_seen = lock_found;
        r.lock_time_s = lock_secs;
        return r;
    endfunction

    function automatic t_result unpack_result(logic [OUT_TDATA_W-1:0] d);
        t_result r;
        r.accepted = d[0];
        r.time_error = d[64:1];
        r.error_valid = d[65];
        r.min_err = d[129:66];
        r.max_err = d[193:130];
        r.sum_err = d[257:194];
        r.valid_count = d[289:258];
        r.outlier_cnt = d[321:290];
        r.best_good_run = d[353:322];
        r.locked = d[354];
        r.lock_seen = d[355];
        r.lock_time_s = d[387:356];
        return r;
    endfunction

    // Builds a sync event whose fields give the wanted time error.
    function automatic t_in_rec build_event(logic [15:0] seq, logic [63:0] err,
                                            logic [63:0] dly, logic [63:0] corr,
                                            logic [63:0] arrival);
        t_in_rec ev;
        ev.cmd = 1'b0;
        ev.master_tx = rand64();
        if (ev.master_tx == 0) ev.master_tx = 64'd1;
        ev.link_delay = dly;
        ev.correction = corr;
        ev.slave_rx = ev.master_tx + dly + corr + err;
        ev.seq = seq;
        ev.arrival = arrival;
        return ev;
    endfunction

    function automatic t_in_rec build_clear();
        t_in_rec ev;
        ev = build_event(16'($urandom), rand64(), rand64(), rand64(), rand64());
        ev.cmd = 1'b1;
        return ev;
    endfunction

    function automatic logic [63:0] next_arrival();
        arrival_ns = arrival_ns + 64'($urandom_range(1, 250000000));
        return arrival_ns;
    endfunction

    // Signed error with most of its weight inside the target.
    function automatic logic [63:0] pick_error(logic [TARGET_W-1:0] target);
        logic [63:0] mag;
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5, 6: mag = 64'($urandom_range(0, target));
            7: mag = target + 64'd1 + 64'($urandom_range(0, 1000));
            8: mag = MAX_ERR_NS - 64'd1 + 64'($urandom_range(0, 2));
            9: mag = 64'($urandom_range(0, 10000000));
            default: return rand64();
        endcase
        return $urandom_range(0, 1) ? (64'd0 - mag) : mag;
    endfunction

    // Well-formed event with random content, some noise and broken ones.
    function automatic t_in_rec random_event();
        t_in_rec     ev;
        logic [15:0] seq;
        logic [63:0] dly;
        logic [63:0] corr;
        logic [63:0] arrival;
        case ($urandom_range(0, 19))
            0: seq = last_seq;
            1: seq = 16'($urandom);
            default: seq = last_seq + 16'd1;
        endcase
        case ($urandom_range(0, 19))
            0, 1: dly = rand64();
            2: dly = MAX_DELAY_NS + 64'($urandom_range(0, 1));
            default: dly = 64'($urandom_range(0, 1000000));
        endcase
        if ($urandom_range(0, 9) < 3) begin
            corr = rand64();
        end else begin
            corr = 64'($urandom_range(0, 100000));
            if ($urandom_range(0, 1)) corr = 64'd0 - corr;
        end
        if ($urandom_range(0, 29) == 0) begin
            arrival_ns = rand64();
            arrival = arrival_ns;
        end else begin
            arrival = next_arrival();
        end
        ev = build_event(seq, pick_error(cfg_target), dly, corr, arrival);
        if ($urandom_range(0, 39) == 0) ev.master_tx = '0;
        if ($urandom_range(0, 39) == 0) ev.slave_rx = '0;
        if ($urandom_range(0, 49) == 0) ev = build_clear();
        return ev;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("result %0d: %s is %h, expected %h", result_index, field, got, want);
        mismatch_count++;
    endtask

    task automatic check_result(t_result got, t_result want);
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
        if (got.time_error !== want.time_error)
            report_mismatch("time_error_ns", got.time_error, want.time_error);
        if (got.error_valid !== want.error_valid)
            report_mismatch("error_valid", got.error_valid, want.error_valid);
        if (got.min_err !== want.min_err)
            report_mismatch("min_error_ns", got.min_err, want.min_err);
        if (got.max_err !== want.max_err)
            report_mismatch("max_error_ns", got.max_err, want.max_err);
        if (got.sum_err !== want.sum_err)
            report_mismatch("error_sum_ns", got.sum_err, want.sum_err);
        if (got.valid_count !== want.valid_count)
            report_mismatch("valid_count", got.valid_count, want.valid_count);
        if (got.outlier_cnt !== want.outlier_cnt)
            report_mismatch("outlier_cnt", got.outlier_cnt, want.outlier_cnt);
        if (got.best_good_run !== want.best_good_run)
            report_mismatch("best_good_run", got.best_good_run, want.best_good_run);
        if (got.locked !== want.locked)
            report_mismatch("locked", got.locked, want.locked);
        if (got.lock_seen !== want.lock_seen)
            report_mismatch("lock_seen", got.lock_seen, want.lock_seen);
        if (got.lock_time_s !== want.lock_time_s)
            report_mismatch("lock_time_s", got.lock_time_s, want.lock_time_s);
    endtask

    // Sends a beat after a random gap, if enabled; records its expected result.
    task automatic send_beat(t_in_rec ev);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ev.cmd;
        s_axis_tdata <= {ev.arrival, ev.seq, ev.correction, ev.link_delay,
                         ev.slave_rx, ev.master_tx};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_stats.insert(pending_stats.size(), compute_monitor_result(ev));
    endtask

    // Holds the input until every expected result beat has come back.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_stats.size() != 0);
    endtask

    // Writes the enable then the target register; only called while idle.
    task automatic write_config(bit en, logic [TARGET_W-1:0] target);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_ENABLE;
        i_cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, en};
        @(posedge i_clk);
        cfg_en = en;
        i_cfg_idx <= CFG_TARGET;
        i_cfg_wdata <= target;
        @(posedge i_clk);
        cfg_target = target;
        i_cfg_we <= 1'b0;
    endtask

    // Disabled events are ignored, clears work while disabled, and sequence
    // zero right after reset counts as a duplicate.
    task automatic test_enable_and_duplicates();
        send_beat(build_event(16'd7, 64'd0, 64'd0, 64'd0, next_arrival()));
        send_beat(build_clear());
        wait_for_results();
        write_config(1'b1, TARGET_RESET);
        send_beat(build_event(16'd0, 64'd3, 64'd10, 64'd0, next_arrival()));
        send_beat(build_event(16'd1, 64'd0, 64'd0, 64'd0, next_arrival()));
        send_beat(build_event(16'd1, 64'd0, 64'd0, 64'd0, next_arrival()));
    endtask

    // Zero timestamps, error and delay limits, the most negative error and
    // all-ones fields.
    task automatic test_validity_limits();
        t_in_rec ev;
        ev = build_event(16'd2, 64'd4, 64'd100, 64'd0, next_arrival());
        ev.master_tx = '0;
        send_beat(ev);
        ev = build_event(16'd3, 64'd4, 64'd100, 64'd0, next_arrival());
        ev.slave_rx = '0;
        send_beat(ev);
        send_beat(build_event(16'd4, MAX_ERR_NS, 64'd0, 64'd0, next_arrival()));
        send_beat(build_event(16'd5, MAX_ERR_NS + 64'd1, 64'd0, 64'd0, next_arrival()));
        send_beat(build_event(16'd6, 64'd0 - MAX_ERR_NS, 64'd0, 64'd0, next_arrival()));
        send_beat(build_event(16'd7, ERR_MIN_NEG, 64'd0, 64'd0, next_arrival()));
        send_beat(build_event(16'd8, 64'd80, 64'd500, 64'd0, next_arrival()));
        send_beat(build_event(16'd9, 64'd0 - 64'd81, 64'd500, 64'd0, next_arrival()));
        send_beat(build_event(16'd10, 64'd0, MAX_DELAY_NS, 64'd0, next_arrival()));
        send_beat(build_event(16'd11, 64'd0, MAX_DELAY_NS + 64'd1, 64'd0, next_arrival()));
        ev = '1;
        ev.cmd = 1'b0;
        send_beat(ev);
        send_beat(build_event(16'd0, 64'd5, 64'd700, 64'd0 - 64'd12345, next_arrival()));
    endtask

    // A run of good events finds the lock point; after a clear a huge arrival
    // gap saturates the lock seconds.
    task automatic test_lock_detection();
        for (int i = 0; i < 5; i++) begin
            send_beat(build_event(16'(100 + i), 64'd0 - 64'($urandom_range(0, 80)),
                                  64'd20, 64'd0, next_arrival()));
        end
        send_beat(build_clear());
        for (int i = 0; i < 5; i++) begin
            send_beat(build_event(16'(200 + i), 64'($urandom_range(0, 80)), 64'd20, 64'd0,
                                  (i == 4) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0));
        end
    endtask

    task automatic run_traffic_phase(int n, bit en, logic [TARGET_W-1:0] target,
                                     bit src_idle, bit sink_idle, bit with_clear);
        wait_for_results();
        write_config(en, target);
        src_idle_on = src_idle;
        sink_idle_on = sink_idle;
        if (with_clear) send_beat(build_clear());
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) == 0) wait_for_results();
            send_beat(random_event());
        end
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_random_traffic();
        run_traffic_phase(150, 1'b1, TARGET_RESET, 1'b1, 1'b1, 1'b1);
        run_traffic_phase(100, 1'b1, '0, 1'b0, 1'b0, 1'b0);
        run_traffic_phase(100, 1'b1, 24'd10000000, 1'b1, 1'b0, 1'b1);
        run_traffic_phase(30, 1'b0, 24'd10000000, 1'b1, 1'b1, 1'b0);
        run_traffic_phase(100, 1'b1, 24'($urandom_range(0, 10000000)), 1'b0, 1'b1, 1'b0);
        run_traffic_phase(150, 1'b1, 24'($urandom_range(0, 200)), 1'b1, 1'b1, 1'b1);
    endtask

    // Result side: random stalls and a field-by-field check of each beat.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_stats.size() == 0) begin
                report_mismatch("beat with nothing expected", '0, '0);
            end else begin
                check_result(unpack_result(m_axis_tdata), pending_stats[0]);
                pending_stats.delete(0);
            end
            result_index++;
            sink_wait = sink_idle_on ? $urandom_range(0, 7) : 0;
        end else if (sink_wait != 0) begin
            sink_wait--;
        end
        m_axis_tready <= (sink_wait == 0);
    end

    // Watchdog on cycles in which no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cfg_en = 1'b0;
        cfg_target = TARGET_RESET;
        last_seq = '0;
        clear_statistics();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_enable_and_duplicates();
        test_validity_limits();
        test_lock_detection();
        test_random_traffic();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
